### design/wcm_pkg.sv
package wcm_pkg;

  localparam int unsigned SCREEN_WIDTH    = 1024;
  localparam int unsigned SCREEN_HEIGHT   = 512;
  localparam int unsigned RAY_COUNT       = 1024;
  localparam int unsigned PROJ_DIST       = 256;
  localparam int unsigned CELL_SIZE       = 64;
  localparam int unsigned VIEW_ANGLE_MDEG = 60000;

  localparam int unsigned ROM_DEPTH = 1024;
  localparam logic [17:0] ROM_MAX   = 18'h3FFFF;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Hit position fraction is held over CELL_SIZE * 2^36 (CELL_SIZE is a power of two).
  localparam int unsigned FRAC_W = $clog2(CELL_SIZE) + 36;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_PLAYER_X   = 3'd0,
    CFG_PLAYER_Y   = 3'd1,
    CFG_TEX_WIDTH  = 3'd2,
    CFG_TEX_HEIGHT = 3'd3,
    CFG_LINE_BYTES = 3'd4,
    CFG_TEXEL_BYTES = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]         ray_index;
    logic [23:0]        distance;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [1:0]         wall_side;
    logic [8:0]         screen_row;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  screen_column;
    logic        in_wall;
    logic [11:0] texel_x;
    logic [11:0] texel_y;
    logic [27:0] texel_offset;
  } out_item_t;

  // Result of the texture column path, handed to the height divider.
  typedef struct packed {
    logic [9:0]  col;
    logic [23:0] hit_dist;
    logic [8:0]  row;
    logic [11:0] tx;
  } xres_t;

  // Result of the height divider: half of the wall height.
  typedef struct packed {
    logic [9:0]  col;
    logic [8:0]  row;
    logic [11:0] tx;
    logic [24:0] half;
  } hres_t;

  // Result of the row divider.
  typedef struct packed {
    logic [9:0]  col;
    logic        in_span;
    logic [11:0] tx;
    logic [11:0] ty;
  } yres_t;

  typedef logic [17:0] rom_arr_t [ROM_DEPTH];

  // Shift and subtract quotient, evaluated only while the ROM contents are built.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Reciprocal cosine, Q4.14, from a truncated Taylor series of cos in Q2.30.
  function automatic logic [17:0] rom_entry(int unsigned idx);
    longint          a;
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    longint unsigned k;
    a = longint'((longint'(idx) * longint'(VIEW_ANGLE_MDEG)) >> $clog2(RAY_COUNT))
        - longint'(VIEW_ANGLE_MDEG >> 1);
    m = (a < 0) ? longint'(-a) : longint'(a);
    m = m % 64'd360000;
    if (m > 64'd180000) m = 64'd360000 - m;
    if (m >= 64'd90000) return ROM_MAX;
    x = (m * PI_Q30) / 64'd180000;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = longint'(term);
    for (k = 1; k <= 12; k++) begin
      term = udiv64((term * x2) >> 30, (2 * k - 1) * (2 * k));
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum <= 0) return ROM_MAX;
    r = udiv64((64'd1 << 44) + (64'(sum) >> 1), 64'(sum));
    if (r > 64'(ROM_MAX)) return ROM_MAX;
    return r[17:0];
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t t;
    for (int i = 0; i < int'(ROM_DEPTH); i++) begin
      t[i] = rom_entry(i);
    end
    return t;
  endfunction

  localparam rom_arr_t INV_COS_ROM = build_rom();

endpackage

### design/wcm_texx.sv
module wcm_texx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  wcm_pkg::in_item_t item_i,
  input  logic [23:0]       player_x,
  input  logic [23:0]       player_y,
  input  logic [12:0]       tex_width,
  output logic              vld_o,
  output wcm_pkg::xres_t    res_o
);
  import wcm_pkg::*;

  localparam int unsigned COL_SHIFT = $clog2(RAY_COUNT);

  logic [3:0] v_r;

  // Stage a: ROM read and side selection.
  logic [17:0]        a_inv_r;
  logic [23:0]        a_dist_r;
  logic signed [15:0] a_dir_r;
  logic               a_mir_r;
  logic [23:0]        a_pl_r;
  logic [9:0]         a_col_r;
  logic [8:0]         a_row_r;
  // Stage b: distance times reciprocal cosine.
  logic [41:0]        b_p_r;
  logic signed [15:0] b_dir_r;
  logic               b_mir_r;
  logic [23:0]        b_pl_r, b_dist_r;
  logic [9:0]         b_col_r;
  logic [8:0]         b_row_r;
  // Stage c: ray length times direction.
  logic [FRAC_W-1:0]  c_t_r;
  logic               c_mir_r;
  logic [23:0]        c_pl_r, c_dist_r;
  logic [9:0]         c_col_r;
  logic [8:0]         c_row_r;
  // Stage d: fraction of the hit position.
  logic [FRAC_W-1:0]  d_f_r;
  logic [23:0]        d_dist_r;
  logic [9:0]         d_col_r;
  logic [8:0]         d_row_r;
  logic [11:0]        e_tx_r;
  logic [23:0]        e_dist_r;
  logic [9:0]         e_col_r;
  logic [8:0]         e_row_r;

  logic [31:0]        col_w;
  logic               far_side;
  logic signed [58:0] dir_prod;
  logic [FRAC_W-1:0]  base, n_w;
  logic [FRAC_W+12:0] tx_prod;
  logic [12:0]        tx_w;

  // RAY_COUNT is a power of two, so the column scaling is a shift.
  assign col_w    = (32'(item_i.ray_index) * 32'(SCREEN_WIDTH)) >> COL_SHIFT;
  assign far_side = item_i.wall_side[1];
  assign dir_prod = $signed({1'b0, b_p_r}) * b_dir_r;
  assign base     = FRAC_W'(({18'd0, c_pl_r} * 42'(CELL_SIZE)) << 28);
  assign n_w      = base + c_t_r;
  assign tx_prod  = d_f_r * tex_width;
  assign tx_w     = tx_prod[FRAC_W+12:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      vld_o <= 1'b0;
    end else if (adv) begin
      v_r   <= {v_r[2:0], vld_i};
      vld_o <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_inv_r  <= INV_COS_ROM[item_i.ray_index];
      a_dist_r <= (item_i.distance == 24'd0) ? 24'd1 : item_i.distance;
      a_dir_r  <= far_side ? item_i.dir_y : item_i.dir_x;
      a_mir_r  <= far_side ? item_i.dir_x[15]
                           : (!item_i.dir_y[15] && item_i.dir_y != 16'sd0);
      a_pl_r   <= far_side ? player_y : player_x;
      a_col_r  <= (col_w > 32'd1023) ? 10'd1023 : col_w[9:0];
      a_row_r  <= item_i.screen_row;

      b_p_r    <= a_dist_r * a_inv_r;
      b_dir_r  <= a_dir_r;
      b_mir_r  <= a_mir_r;
      b_pl_r   <= a_pl_r;
      b_dist_r <= a_dist_r;
      b_col_r  <= a_col_r;
      b_row_r  <= a_row_r;

      c_t_r    <= dir_prod[FRAC_W-1:0];
      c_mir_r  <= b_mir_r;
      c_pl_r   <= b_pl_r;
      c_dist_r <= b_dist_r;
      c_col_r  <= b_col_r;
      c_row_r  <= b_row_r;

      // Mirroring 1 - pos modulo one cell is the two's complement of the fraction.
      d_f_r    <= c_mir_r ? (~n_w + 1'b1) : n_w;
      d_dist_r <= c_dist_r;
      d_col_r  <= c_col_r;
      d_row_r  <= c_row_r;

      e_tx_r   <= tx_w[12] ? 12'hFFF : tx_w[11:0];
      e_dist_r <= d_dist_r;
      e_col_r  <= d_col_r;
      e_row_r  <= d_row_r;
    end
  end

  assign res_o = '{col: e_col_r, hit_dist: e_dist_r, row: e_row_r, tx: e_tx_r};

endmodule

### design/wcm_hdiv.sv
module wcm_hdiv (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           vld_i,
  input  wcm_pkg::xres_t res_i,
  output logic           vld_o,
  output wcm_pkg::hres_t res_o
);
  import wcm_pkg::*;

  // Restoring division of SCREEN_HEIGHT * PROJ_DIST * 256 by the distance, one bit a stage.
  localparam int unsigned NUM     = SCREEN_HEIGHT * PROJ_DIST * 256;
  localparam int unsigned QW      = $clog2(NUM) + 1;
  localparam logic [QW-1:0] NUM_V = QW'(NUM);

  logic [QW-1:0]  v_r;
  logic [23:0]    rem_r [QW];
  logic [QW-1:0]  q_r   [QW];
  xres_t          pay_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [23:0]   rem_in;
    logic [QW-1:0] q_in;
    xres_t         pay_in;
    logic [24:0]   cand;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign pay_in = res_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign pay_in = pay_r[k-1];
    end

    assign cand = {rem_in, NUM_V[QW-1-k]};
    assign ge   = cand >= {1'b0, pay_in.hit_dist};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? 24'(cand - {1'b0, pay_in.hit_dist}) : cand[23:0];
        q_r[k]   <= q_in | (ge ? (QW'(1) << (QW - 1 - k)) : '0);
        pay_r[k] <= pay_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[QW-2:0], vld_i};
    end
  end

  assign vld_o = v_r[QW-1];
  assign res_o = '{col: pay_r[QW-1].col, row: pay_r[QW-1].row, tx: pay_r[QW-1].tx,
                   half: 25'(q_r[QW-1] >> 1)};

endmodule

### design/wcm_ydiv.sv
module wcm_ydiv (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           vld_i,
  input  wcm_pkg::hres_t res_i,
  input  logic [12:0]    tex_height,
  output logic           vld_o,
  output wcm_pkg::yres_t res_o
);
  import wcm_pkg::*;

  localparam logic [25:0] MID = 26'(SCREEN_HEIGHT / 2);
  localparam int unsigned NS  = 13;

  logic [NS+1:0] v_r;

  // Stage a: span test.
  logic        a_in_r;
  logic [24:0] a_rel_r;
  logic [25:0] a_span_r;
  logic [9:0]  a_col_r;
  logic [11:0] a_tx_r;
  // Stage b: relative row times texture height.
  logic [37:0] b_d_r;
  logic        b_in_r;
  logic [25:0] b_span_r;
  logic [9:0]  b_col_r;
  logic [11:0] b_tx_r;

  logic [25:0] rsum;
  logic        in_span;

  logic [25:0] rem_r [NS];
  logic [NS-1:0] q_r [NS];
  logic [12:0] lo_r  [NS];
  logic [25:0] sp_r  [NS];
  logic        in_r  [NS];
  logic [9:0]  col_r [NS];
  logic [11:0] tx_r  [NS];

  assign rsum    = 26'(res_i.row) + 26'(res_i.half);
  assign in_span = (rsum >= MID) && (26'(res_i.row) < (MID + 26'(res_i.half)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_in_r   <= in_span;
      a_rel_r  <= in_span ? 25'(rsum - MID) : '0;
      a_span_r <= {res_i.half, 1'b0};
      a_col_r  <= res_i.col;
      a_tx_r   <= res_i.tx;

      b_d_r    <= a_rel_r * tex_height;
      b_in_r   <= a_in_r;
      b_span_r <= a_span_r;
      b_col_r  <= a_col_r;
      b_tx_r   <= a_tx_r;
    end
  end

  // The quotient stays below the texture height, so the top bits seed the remainder.
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [25:0]   rem_in;
    logic [NS-1:0] q_in;
    logic [12:0]   lo_in;
    logic [25:0]   sp_in;
    logic          in_in;
    logic [9:0]    col_in;
    logic [11:0]   tx_in;
    logic [26:0]   cand;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, b_d_r[37:13]};
      assign q_in   = '0;
      assign lo_in  = b_d_r[12:0];
      assign sp_in  = b_span_r;
      assign in_in  = b_in_r;
      assign col_in = b_col_r;
      assign tx_in  = b_tx_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign sp_in  = sp_r[k-1];
      assign in_in  = in_r[k-1];
      assign col_in = col_r[k-1];
      assign tx_in  = tx_r[k-1];
    end

    assign cand = {rem_in, lo_in[NS-1-k]};
    assign ge   = cand >= {1'b0, sp_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? 26'(cand - {1'b0, sp_in}) : cand[25:0];
        q_r[k]   <= q_in | (ge ? (NS'(1) << (NS - 1 - k)) : '0);
        lo_r[k]  <= lo_in;
        sp_r[k]  <= sp_in;
        in_r[k]  <= in_in;
        col_r[k] <= col_in;
        tx_r[k]  <= tx_in;
      end
    end
  end

  assign vld_o = v_r[NS+1];
  assign res_o = '{col: col_r[NS-1], in_span: in_r[NS-1], tx: tx_r[NS-1],
                   ty: !in_r[NS-1] ? 12'd0 :
                       (q_r[NS-1][12] ? 12'hFFF : q_r[NS-1][11:0])};

endmodule

### design/wall_column_texel_mapper_core.sv
// Texel address generator for raycast wall columns. Each input transaction carries one
// ray's hit (ray index, Q16.8 distance, Q2.14 direction, wall side) and one screen row;
// each yields exactly one output transaction with the screen column, an in-wall flag and
// the texture column, row and byte offset to fetch. A new transaction is taken every
// clock while in_stall is low. The path runs through the input register, five stages for
// the texture column (reciprocal-cosine ROM read, two multiplies, hit fraction, width
// scaling), 26 stages of the restoring wall height divider, two stages plus 13 divider
// stages for the texture row, and the output register. The whole pipeline holds while
// a result sits in the output register under out_stall, so in_stall is high exactly
// then. Configuration registers are written through the cfg_ port, always ready, and
// must only change while no transaction is in flight.
module wall_column_texel_mapper_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wcm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output wcm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import wcm_pkg::*;

  logic [23:0] player_x_r, player_y_r;
  logic [12:0] tex_w_r, tex_h_r;
  logic [15:0] line_bytes_r;
  logic [3:0]  texel_bytes_r;

  logic      adv;
  logic      in_v_r;
  in_item_t  in_item_r;
  logic      x_vld, h_vld, y_vld;
  xres_t     x_res;
  hres_t     h_res;
  yres_t     y_res;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic [27:0] off_w;

  // The register file accepts a write on every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r    <= '0;
      player_y_r    <= '0;
      tex_w_r       <= 13'd64;
      tex_h_r       <= 13'd64;
      line_bytes_r  <= 16'd256;
      texel_bytes_r <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PLAYER_X:    player_x_r    <= cfg_data;
        CFG_PLAYER_Y:    player_y_r    <= cfg_data;
        CFG_TEX_WIDTH:   tex_w_r       <= cfg_data[12:0];
        CFG_TEX_HEIGHT:  tex_h_r       <= cfg_data[12:0];
        CFG_LINE_BYTES:  line_bytes_r  <= cfg_data[15:0];
        CFG_TEXEL_BYTES: texel_bytes_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Every stage moves together; the pipeline only holds while a finished result is
  // waiting to be taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (adv) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_item_r <= in_item;
    end
  end

  wcm_texx u_texx (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .vld_i     (in_v_r),
    .item_i    (in_item_r),
    .player_x  (player_x_r),
    .player_y  (player_y_r),
    .tex_width (tex_w_r),
    .vld_o     (x_vld),
    .res_o     (x_res)
  );

  wcm_hdiv u_hdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (x_vld),
    .res_i (x_res),
    .vld_o (h_vld),
    .res_o (h_res)
  );

  wcm_ydiv u_ydiv (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .vld_i      (h_vld),
    .res_i      (h_res),
    .tex_height (tex_h_r),
    .vld_o      (y_vld),
    .res_o      (y_res)
  );

  // Byte offset wraps at 28 bits; rows outside the span report a zero offset.
  assign off_w = (28'(y_res.ty) * 28'(line_bytes_r)) + (28'(y_res.tx) * 28'(texel_bytes_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= y_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.screen_column <= y_res.col;
      out_item_r.in_wall       <= y_res.in_span;
      out_item_r.texel_x       <= y_res.tx;
      out_item_r.texel_y       <= y_res.ty;
      out_item_r.texel_offset  <= y_res.in_span ? off_w : 28'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_outside_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.in_wall) |-> (out_item.texel_y == 12'd0 &&
                                         out_item.texel_offset == 28'd0))
    else $error("row outside the wall span carries a texel row or offset");

  a_tx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && tex_w_r != 13'd0) |-> (13'(out_item.texel_x) < tex_w_r))
    else $error("texel column beyond texture width");

endmodule
